@@ hw/rtl/ufp_pkg.sv @@
// Package for the delimited serial frame parser.
// Holds the frame and number parse state types and the configuration
// register indexes. No dependencies.
package ufp_pkg;

  // Frame phase; the fourth code behaves as hunting
  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_TAG     = 2'd1,
    PH_PAYLOAD = 2'd2
  } frame_phase_e;

  // Decimal text parse phase
  typedef enum logic [2:0] {
    NP_LEAD = 3'd0,
    NP_SIGN = 3'd1,
    NP_INT  = 3'd2,
    NP_FRAC = 3'd3,
    NP_DONE = 3'd4
  } num_phase_e;

  localparam int unsigned MantW = 47;
  localparam int unsigned FracW = 5;

  localparam logic [MantW-1:0] MantMax = {MantW{1'b1}};
  localparam logic [FracW-1:0] FracMax = {FracW{1'b1}};

  // Running state of the decimal parse
  typedef struct packed {
    logic             negative;
    logic [MantW-1:0] mantissa;
    logic [FracW-1:0] frac_count;
    num_phase_e       phase;
  } num_state_t;

  localparam num_state_t NumStateInit = '{
    negative:   1'b0,
    mantissa:   '0,
    frac_count: '0,
    phase:      NP_LEAD
  };

  // Configuration register indexes
  localparam logic [7:0] RegStartByte    = 8'd0;
  localparam logic [7:0] RegEndByte      = 8'd1;
  localparam logic [7:0] RegDirectionTag = 8'd2;
  localparam logic [7:0] RegAngleTag     = 8'd3;

  // Characters seen by the parser
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPoint = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;

endpackage

@@ hw/rtl/ufp_num_parse.sv @@
// One step of the incremental decimal text parser: takes the current parse
// state and one payload byte, gives the next parse state.
// Depends on ufp_pkg.
module ufp_num_parse import ufp_pkg::*; (
  input  num_state_t  state_i,
  input  logic [7:0]  char_i,
  output num_state_t  state_o
);

  localparam int unsigned ProdW = MantW + 4;

  logic             is_digit;
  logic             is_blank;
  logic             is_sign;
  logic             take_num;
  logic [ProdW-1:0] prod;
  logic [MantW-1:0] mant_next;

  // Classify the character
  assign is_digit = (char_i >= ChZero) && (char_i <= ChNine);
  assign is_blank = (char_i == ChSpace) || ((char_i >= ChTab) && (char_i <= ChCr));
  assign is_sign  = (char_i == ChPlus) || (char_i == ChMinus);

  // Append the digit: acc*10 + d, saturate at the mantissa limit
  assign prod = {1'b0, state_i.mantissa, 3'b000} + {3'b000, state_i.mantissa, 1'b0}
              + {{(ProdW-4){1'b0}}, char_i[3:0]};
  assign mant_next = (prod > {4'b0000, MantMax}) ? MantMax : prod[MantW-1:0];

  // Integer part handling shared by the lead, sign and integer phases
  assign take_num = ((state_i.phase == NP_LEAD) && !is_blank && !is_sign) ||
                    (state_i.phase == NP_SIGN) || (state_i.phase == NP_INT);

  always_comb begin
    state_o = state_i;
    if (take_num) begin
      if (is_digit) begin
        state_o.mantissa = mant_next;
        state_o.phase    = NP_INT;
      end else if (char_i == ChPoint) begin
        state_o.phase = NP_FRAC;
      end else begin
        state_o.phase = NP_DONE;
      end
    end else begin
      case (state_i.phase)
        NP_LEAD: begin
          // Blanks hold; a sign opens the number
          if (is_sign) begin
            state_o.negative = (char_i == ChMinus);
            state_o.phase    = NP_SIGN;
          end
        end
        NP_FRAC: begin
          if (is_digit) begin
            state_o.mantissa = mant_next;
            if (state_i.frac_count != FracMax) begin
              state_o.frac_count = state_i.frac_count + 1'b1;
            end
          end else begin
            state_o.phase = NP_DONE;
          end
        end
        default: begin
          state_o = state_i;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/uart_frame_parser_decimal_field.sv @@
// Delimited serial frame parser with a decimal angle field.
// A result word appears on the output in the cycle after the end byte is
// accepted. Throughput: one byte word per cycle, set by the single
// registered update of frame and parse state; a byte is taken in the cycle a
// waiting result leaves, and a result held by the receiver stalls the input.
// Reset clears the frame state, the stored slot-0 byte and the output valid,
// and loads the register defaults.
module uart_frame_parser_decimal_field import ufp_pkg::*; #(
  parameter int unsigned MAX_LEN = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  // Byte input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  // Result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               kind_o,
  output logic [7:0]         direction_o,
  output logic signed [47:0] angle_mantissa_o,
  output logic [4:0]         angle_frac_digits_o
);

  localparam int unsigned CntW = $clog2(MAX_LEN + 1);

  // Configuration registers
  logic [7:0] start_byte_q, end_byte_q, direction_tag_q, angle_tag_q;

  // Frame state
  frame_phase_e  phase_q, phase_d;
  logic [7:0]    tag_q, tag_d;
  logic [CntW-1:0] count_q, count_d;
  logic [7:0]    slot0_q, slot0_d;
  num_state_t    num_q, num_d, num_step;

  // Result
  logic          in_fire;
  logic          res_valid;
  logic          res_kind;
  logic [7:0]    res_dir;
  logic [47:0]   res_mant;
  logic [4:0]    res_frac;
  logic          out_valid_q, out_valid_d;
  logic          kind_q;
  logic [7:0]    dir_q;
  logic [47:0]   mant_q;
  logic [4:0]    frac_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q    <= 8'd170;
      end_byte_q      <= 8'd85;
      direction_tag_q <= 8'd1;
      angle_tag_q     <= 8'd2;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegStartByte:    start_byte_q    <= cfg_data_i;
        RegEndByte:      end_byte_q      <= cfg_data_i;
        RegDirectionTag: direction_tag_q <= cfg_data_i;
        RegAngleTag:     angle_tag_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance the decimal parser by one payload byte
  ufp_num_parse u_num_parse (
    .state_i (num_q),
    .char_i  (rx_byte_i),
    .state_o (num_step)
  );

  // Next frame state
  always_comb begin
    phase_d = phase_q;
    tag_d   = tag_q;
    count_d = count_q;
    slot0_d = slot0_q;
    num_d   = num_q;
    case (phase_q)
      PH_TAG: begin
        tag_d   = rx_byte_i;
        phase_d = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (rx_byte_i == end_byte_q) begin
          phase_d = PH_HUNT;
        end else if (count_q < CntW'(MAX_LEN)) begin
          if (count_q == '0) begin
            slot0_d = rx_byte_i;
          end
          count_d = count_q + 1'b1;
          num_d   = num_step;
        end else begin
          // Overflow: drop the byte and go back to hunting
          phase_d = PH_HUNT;
        end
      end
      default: begin
        if (rx_byte_i == start_byte_q) begin
          phase_d = PH_TAG;
          count_d = '0;
          num_d   = NumStateInit;
        end
      end
    endcase
  end

  // Result produced by an end byte
  always_comb begin
    res_valid = 1'b0;
    res_kind  = 1'b0;
    res_dir   = '0;
    res_mant  = '0;
    res_frac  = '0;
    if ((phase_q == PH_PAYLOAD) && (rx_byte_i == end_byte_q)) begin
      if (tag_q == direction_tag_q) begin
        res_valid = (count_q <= CntW'(1));
        res_dir   = slot0_q;
      end else if (tag_q == angle_tag_q) begin
        res_valid = 1'b1;
        res_kind  = 1'b1;
        res_mant  = num_q.negative ? (48'd0 - {1'b0, num_q.mantissa})
                                   : {1'b0, num_q.mantissa};
        res_frac  = num_q.frac_count;
      end
    end
  end

  // Hold or replace the output word
  assign out_valid_d = (in_fire && res_valid) || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      tag_q       <= '0;
      count_q     <= '0;
      slot0_q     <= '0;
      num_q       <= NumStateInit;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        phase_q <= phase_d;
        tag_q   <= tag_d;
        count_q <= count_d;
        slot0_q <= slot0_d;
        num_q   <= num_d;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      kind_q <= res_kind;
      dir_q  <= res_dir;
      mant_q <= res_mant;
      frac_q <= res_frac;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign kind_o              = kind_q;
  assign direction_o         = dir_q;
  assign angle_mantissa_o    = $signed(mant_q);
  assign angle_frac_digits_o = frac_q;

endmodule
